// File: src/ocx_pkg.sv
// Package for the ordered crossover block: widths, sizes, walk states and the
// status record passed from the loader to the walk sequencer. No dependencies.
`timescale 1ns / 1ps

package ocx_pkg;

  // Longest parent permutation that the stores hold.
  localparam int MAX_LENGTH = 64;

  // Field widths fixed by the interface.
  localparam int VAL_W  = 6;
  localparam int KEEP_W = 7;

  // Number of distinct element values, one mark bit each.
  localparam int VAL_COUNT = 1 << VAL_W;

  // Store address and element count widths.
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

  // Walk sequencer states.
  typedef enum logic [2:0] {
    WS_IDLE,
    WS_KEEP,
    WS_POS,
    WS_FIRST,
    WS_SECOND,
    WS_EMIT
  } walk_state_t;

  // What the loader hands to the walk once the last pair is in.
  typedef struct packed {
    logic             running;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] kb;
    logic [CNT_W-1:0] ke;
    logic             invalid;
  } load_info_t;

endpackage

// File: src/ocx_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ocx_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ocx_load.sv
// Parent loader: counts stored pairs, tracks repeated and largest values,
// and latches the clamped kept range. Depends on ocx_pkg.
`timescale 1ns / 1ps

module ocx_load (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [ocx_pkg::VAL_W-1:0]  first_parent_value,
  input  logic [ocx_pkg::VAL_W-1:0]  second_parent_value,
  input  logic [ocx_pkg::KEEP_W-1:0] keep_begin,
  input  logic [ocx_pkg::KEEP_W-1:0] keep_end,
  input  logic                     last_element,
  input  logic                     done,
  output logic                     we,
  output logic [ocx_pkg::ADDR_W-1:0] waddr,
  output ocx_pkg::load_info_t      info
);
  import ocx_pkg::*;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [VAL_COUNT-1:0] first_seen;
  logic [VAL_COUNT-1:0] second_seen;
  logic                 dup;
  logic [VAL_W-1:0]     max_val;
  logic [VAL_W-1:0]     pair_max;
  logic                 running;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     kb;
  logic [CNT_W-1:0]     ke;

  // A pair is stored only while there is room; extra elements are dropped.
  assign we         = accept && (count < CNT_W'(MAX_LENGTH));
  assign waddr      = count[ADDR_W-1:0];
  assign count_next = count + CNT_W'(we);
  assign pair_max   = (first_parent_value > second_parent_value) ?
                      first_parent_value : second_parent_value;

  // Load bookkeeping, cleared on reset and when the child has been delivered.
  always_ff @(posedge clk) begin
    if (rst || done) begin
      count       <= '0;
      first_seen  <= '0;
      second_seen <= '0;
      dup         <= 1'b0;
      max_val     <= '0;
      running     <= 1'b0;
    end else if (accept) begin
      if (we) begin
        count <= count_next;
        if (first_seen[first_parent_value] || second_seen[second_parent_value]) begin
          dup <= 1'b1;
        end
        first_seen[first_parent_value]   <= 1'b1;
        second_seen[second_parent_value] <= 1'b1;
        if (pair_max > max_val) begin
          max_val <= pair_max;
        end
      end
      if (last_element) begin
        running <= 1'b1;
      end
    end
  end

  // Length and clamped range, taken from the last transaction.
  always_ff @(posedge clk) begin
    if (accept && last_element) begin
      n  <= count_next;
      kb <= (keep_begin > KEEP_W'(count_next)) ? count_next : keep_begin[CNT_W-1:0];
      ke <= (keep_end > KEEP_W'(count_next)) ? count_next : keep_end[CNT_W-1:0];
    end
  end

  assign info.running = running;
  assign info.n       = n;
  assign info.kb      = kb;
  assign info.ke      = ke;
  assign info.invalid = dup || (KEEP_W'(max_val) >= KEEP_W'(n));

endmodule

// File: src/ocx_walk.sv
// Crossover walk sequencer: marks the kept values, then builds the child one
// position at a time from the two parent stores. Depends on ocx_pkg.
`timescale 1ns / 1ps

module ocx_walk (
  input  logic                       clk,
  input  logic                       rst,
  input  ocx_pkg::load_info_t        info,
  input  logic [ocx_pkg::VAL_W-1:0]  first_rdata,
  input  logic [ocx_pkg::VAL_W-1:0]  second_rdata,
  input  logic                       out_stall,
  output logic [ocx_pkg::ADDR_W-1:0] first_raddr,
  output logic [ocx_pkg::ADDR_W-1:0] second_raddr,
  output logic                       out_valid,
  output logic [ocx_pkg::VAL_W-1:0]  child_value,
  output logic                       child_last,
  output logic                       parents_invalid,
  output logic                       done
);
  import ocx_pkg::*;

  walk_state_t          state;
  walk_state_t          state_next;
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     pos_next;
  logic [CNT_W-1:0]     j;
  logic [CNT_W-1:0]     j_next;
  logic                 pend;
  logic                 pend_next;
  logic [VAL_W-1:0]     out_val;
  logic [VAL_W-1:0]     out_val_next;
  logic [VAL_COUNT-1:0] kept;
  logic                 in_range;
  logic                 is_last;

  assign in_range = (pos >= info.kb) && (pos < info.ke);
  assign is_last  = (pos + CNT_W'(1)) == info.n;

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
      pos   <= '0;
      j     <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      j     <= j_next;
      pend  <= pend_next;
    end
  end

  // Child value register, held while the result is stalled.
  always_ff @(posedge clk) begin
    out_val <= out_val_next;
  end

  // Kept value marks; each is set from the registered read data of the first store, flagged by pend.
  always_ff @(posedge clk) begin
    if (rst || done) begin
      kept <= '0;
    end else if (pend) begin
      kept[first_rdata] <= 1'b1;
    end
  end

  // Next state and control.
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    j_next       = j;
    pend_next    = 1'b0;
    out_val_next = out_val;
    done         = 1'b0;
    unique case (state)
      WS_IDLE: begin
        if (info.running) begin
          pos_next   = info.kb;
          j_next     = '0;
          state_next = WS_KEEP;
        end
      end
      WS_KEEP: begin
        if (pos < info.ke) begin
          pos_next  = pos + CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pos_next   = '0;
          state_next = WS_POS;
        end
      end
      WS_POS: begin
        if (in_range) begin
          state_next = WS_FIRST;
        end else if (j < info.n) begin
          state_next = WS_SECOND;
        end else begin
          out_val_next = '0;
          state_next   = WS_EMIT;
        end
      end
      WS_FIRST: begin
        out_val_next = first_rdata;
        state_next   = WS_EMIT;
      end
      WS_SECOND: begin
        j_next = j + CNT_W'(1);
        if (kept[second_rdata]) begin
          state_next = WS_POS;
        end else begin
          out_val_next = second_rdata;
          state_next   = WS_EMIT;
        end
      end
      WS_EMIT: begin
        if (!out_stall) begin
          if (is_last) begin
            done       = 1'b1;
            state_next = WS_IDLE;
          end else begin
            pos_next   = pos + CNT_W'(1);
            state_next = WS_POS;
          end
        end
      end
      default: begin
        state_next = WS_IDLE;
      end
    endcase
  end

  assign first_raddr     = pos[ADDR_W-1:0];
  assign second_raddr    = j[ADDR_W-1:0];
  assign out_valid       = (state == WS_EMIT);
  assign child_value     = out_val;
  assign child_last      = is_last;
  assign parents_invalid = info.invalid;

endmodule

// File: src/permutation_ordered_crossover.sv
// Ordered crossover of two permutations. Parent element pairs are accepted one
// per cycle; the transaction marked last_element also carries the kept range
// and starts the crossover, during which input stays stalled. After a start
// state the crossover sweeps the kept range of the first parent store, marking
// each kept value, then emits the child: a position inside the kept range takes
// the first parent value, any other takes the next second-parent value that is
// not kept, skipping the kept ones, or zero when the second parent has no unused
// value left; each child value is held while the output is stalled. This walk is
// paced by the single read port of each parent store and the mark lookup of the
// walk sequencer. Input is taken again in the cycle after the final child
// transaction.
// Top level; depends on ocx_pkg, ocx_ram, ocx_load and ocx_walk.
`timescale 1ns / 1ps

module permutation_ordered_crossover (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ocx_pkg::VAL_W-1:0]  first_parent_value,
  input  logic [ocx_pkg::VAL_W-1:0]  second_parent_value,
  input  logic [ocx_pkg::KEEP_W-1:0] keep_begin,
  input  logic [ocx_pkg::KEEP_W-1:0] keep_end,
  input  logic                       last_element,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ocx_pkg::VAL_W-1:0]  child_value,
  output logic                       child_last,
  output logic                       parents_invalid
);
  import ocx_pkg::*;

  logic              accept;
  logic              done;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] first_raddr;
  logic [ADDR_W-1:0] second_raddr;
  logic [VAL_W-1:0]  first_rdata;
  logic [VAL_W-1:0]  second_rdata;
  load_info_t        info;

  // Input is taken only while no crossover is running.
  assign in_stall = info.running;
  assign accept   = in_valid && !in_stall;

  ocx_load u_load (
    .clk                 (clk),
    .rst                 (rst),
    .accept              (accept),
    .first_parent_value  (first_parent_value),
    .second_parent_value (second_parent_value),
    .keep_begin          (keep_begin),
    .keep_end            (keep_end),
    .last_element        (last_element),
    .done                (done),
    .we                  (we),
    .waddr               (waddr),
    .info                (info)
  );

  // Parent stores.
  ocx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_first_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (first_parent_value),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  ocx_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LENGTH)) u_second_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (second_parent_value),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  ocx_walk u_walk (
    .clk             (clk),
    .rst             (rst),
    .info            (info),
    .first_rdata     (first_rdata),
    .second_rdata    (second_rdata),
    .out_stall       (out_stall),
    .first_raddr     (first_raddr),
    .second_raddr    (second_raddr),
    .out_valid       (out_valid),
    .child_value     (child_value),
    .child_last      (child_last),
    .parents_invalid (parents_invalid),
    .done            (done)
  );

  // No new parents are taken while a child is being delivered.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input accepted while child output pending");

  // The final child transaction frees the input side.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && child_last) |=> !in_stall)
    else $error("input still stalled after final child element");

  // The invalid flag holds across one child.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !child_last) |=> $stable(parents_invalid))
    else $error("parents_invalid changed within one child");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for permutation_ordered_crossover: it loads parent pairs,
// predicts every child element of the ordered crossover and checks the output stream.
// Depends on ocx_pkg and the permutation_ordered_crossover RTL.
`timescale 1ns / 1ps

module testbench;
  import ocx_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PERCENT = 37;

  typedef logic [VAL_W-1:0] value_queue_t[$];

  // One child element as it should leave the block.
  typedef struct {
    logic [VAL_W-1:0] value;
    logic             is_last;
    logic             invalid;
  } child_item_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [VAL_W-1:0]  first_parent_value;
  logic [VAL_W-1:0]  second_parent_value;
  logic [KEEP_W-1:0] keep_begin;
  logic [KEEP_W-1:0] keep_end;
  logic              last_element;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  child_value;
  logic              child_last;
  logic              parents_invalid;

  // Predictor state: the parents loaded so far and the value marks.
  logic [VAL_W-1:0] first_mem [MAX_LENGTH];
  logic [VAL_W-1:0] second_mem [MAX_LENGTH];
  bit               kept_mark [VAL_COUNT];
  bit               first_mark [VAL_COUNT];
  bit               second_mark [VAL_COUNT];
  int               stored_pairs;
  bit               repeat_found;

  child_item_t expected_children[$];

  int  error_count = 0;
  int  pairs_accepted = 0;
  int  crossovers_started = 0;
  int  children_checked = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  steady_mode = 1'b0;

  permutation_ordered_crossover i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .first_parent_value  (first_parent_value),
    .second_parent_value (second_parent_value),
    .keep_begin          (keep_begin),
    .keep_end            (keep_end),
    .last_element        (last_element),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .child_value         (child_value),
    .child_last          (child_last),
    .parents_invalid     (parents_invalid)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stores one parent pair and, on the final pair, predicts the whole child.
  function automatic void predict_child_elements(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [KEEP_W-1:0] kb_in,
                                                 input logic [KEEP_W-1:0] ke_in,
                                                 input logic is_last);
    int n;
    int kb;
    int ke;
    int j;
    bit invalid;
    logic [VAL_W-1:0] v;
    child_item_t item;
    if (stored_pairs < MAX_LENGTH) begin
      first_mem[stored_pairs] = a;
      second_mem[stored_pairs] = b;
      if (first_mark[a] || second_mark[b]) repeat_found = 1'b1;
      first_mark[a] = 1'b1;
      second_mark[b] = 1'b1;
      stored_pairs++;
    end
    if (!is_last) return;
    crossovers_started++;
    n = stored_pairs;
    kb = (int'(kb_in) > n) ? n : int'(kb_in);
    ke = (int'(ke_in) > n) ? n : int'(ke_in);
    invalid = repeat_found;
    for (int i = 0; i < n; i++) begin
      if (int'(first_mem[i]) >= n || int'(second_mem[i]) >= n) invalid = 1'b1;
    end
    for (int i = kb; i < ke; i++) kept_mark[first_mem[i]] = 1'b1;
    // Walk the positions; outside the kept range take the next unused second value.
    j = 0;
    for (int i = 0; i < n; i++) begin
      if (i >= kb && i < ke) begin
        v = first_mem[i];
      end else begin
        while (j < n && kept_mark[second_mem[j]]) j++;
        if (j < n) begin
          v = second_mem[j];
          j++;
        end else begin
          v = '0;
        end
      end
      item.value = v;
      item.is_last = (i + 1 == n);
      item.invalid = invalid;
      expected_children.push_back(item);
    end
    // Ready for the next pair of parents.
    for (int k = 0; k < VAL_COUNT; k++) begin
      kept_mark[k] = 1'b0;
      first_mark[k] = 1'b0;
      second_mark[k] = 1'b0;
    end
    stored_pairs = 0;
    repeat_found = 1'b0;
  endfunction

  // Builds a random permutation of 0 .. n-1.
  function automatic void make_permutation(input int n, output value_queue_t perm);
    int r;
    logic [VAL_W-1:0] t;
    perm = {};
    for (int k = 0; k < n; k++) perm.push_back(VAL_W'(k));
    for (int k = n - 1; k > 0; k--) begin
      r = $urandom_range(k);
      t = perm[k];
      perm[k] = perm[r];
      perm[r] = t;
    end
  endfunction

  // Sends one parent pair as a transaction, idling at random beforehand outside steady mode.
  task automatic send_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                           input logic [KEEP_W-1:0] kb, input logic [KEEP_W-1:0] ke,
                           input logic is_last);
    @(negedge clk);
    while (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    first_parent_value = a;
    second_parent_value = b;
    keep_begin = kb;
    keep_end = ke;
    last_element = is_last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pairs_accepted++;
    predict_child_elements(a, b, kb, ke, is_last);
  endtask

  // Sends two whole parents; the range rides on the final pair only.
  task automatic send_parents(input value_queue_t first_seq, input value_queue_t second_seq,
                              input int kb, input int ke);
    for (int i = 0; i < first_seq.size(); i++) begin
      if (i == first_seq.size() - 1) begin
        send_pair(first_seq[i], second_seq[i], KEEP_W'(kb), KEEP_W'(ke), 1'b1);
      end else begin
        send_pair(first_seq[i], second_seq[i], KEEP_W'($urandom_range(127)),
                  KEEP_W'($urandom_range(127)), 1'b0);
      end
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_children();
    while (expected_children.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_element();
    send_pair(6'd0, 6'd0, 7'd0, 7'd127, 1'b1);
    // A lone 63 is out of range and the range collapses to empty.
    send_pair(6'd63, 6'd63, 7'd64, 7'd0, 1'b1);
  endtask

  task automatic test_empty_range();
    value_queue_t fa;
    value_queue_t sa;
    fa = '{6'd2, 6'd0, 6'd3, 6'd1};
    sa = '{6'd1, 6'd3, 6'd0, 6'd2};
    send_parents(fa, sa, 3, 1);
  endtask

  task automatic test_clamped_range();
    value_queue_t fa;
    value_queue_t sa;
    fa = '{6'd4, 6'd3, 6'd2, 6'd1, 6'd0};
    sa = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4};
    send_parents(fa, sa, 2, 127);
  endtask

  task automatic test_range_past_length();
    value_queue_t fa;
    value_queue_t sa;
    fa = '{6'd1, 6'd2, 6'd0};
    sa = '{6'd2, 6'd0, 6'd1};
    send_parents(fa, sa, 100, 127);
  endtask

  task automatic test_invalid_parents();
    value_queue_t fa;
    value_queue_t sa;
    // The second parent runs out of unused values, so zeros fill the tail.
    fa = '{6'd0, 6'd1, 6'd2, 6'd3};
    sa = '{6'd0, 6'd1, 6'd1, 6'd0};
    send_parents(fa, sa, 0, 2);
    // A repeat in the first parent and a value past the length in the second.
    fa = '{6'd0, 6'd0, 6'd1};
    sa = '{6'd2, 6'd1, 6'd63};
    send_parents(fa, sa, 1, 2);
  endtask

  // Full-length parents; the pairs beyond the store depth are dropped without a flag.
  task automatic test_too_many_elements();
    value_queue_t fa;
    value_queue_t sa;
    make_permutation(MAX_LENGTH, fa);
    make_permutation(MAX_LENGTH, sa);
    for (int k = 0; k < 3; k++) begin
      fa.push_back(VAL_W'($urandom_range(63)));
      sa.push_back(VAL_W'($urandom_range(63)));
    end
    send_parents(fa, sa, $urandom_range(0, 20), $urandom_range(30, 127));
  endtask

  // The receiver holds off while a second child queues up behind the first.
  task automatic test_output_hold();
    value_queue_t fa;
    value_queue_t sa;
    hold_request = 400;
    for (int k = 0; k < 2; k++) begin
      make_permutation(4, fa);
      make_permutation(4, sa);
      send_parents(fa, sa, k, k + 3);
    end
  endtask

  task automatic test_sender_pause();
    release_input();
    wait_children();
  endtask

  task automatic test_random_crossovers(input int item_goal, input bit steady);
    value_queue_t fa;
    value_queue_t sa;
    int sent;
    int n;
    int kind;
    int kb;
    int ke;
    steady_mode = steady;
    sent = 0;
    while (sent < item_goal) begin
      kind = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 10);
      make_permutation(n, fa);
      make_permutation(n, sa);
      // Some parents are broken with arbitrary values.
      if (kind >= 85) begin
        fa[$urandom_range(n - 1)] = VAL_W'($urandom_range(63));
        sa[$urandom_range(n - 1)] = VAL_W'($urandom_range(63));
      end
      if (kind < 75) begin
        kb = $urandom_range(0, n);
        ke = $urandom_range(0, n);
      end else begin
        kb = $urandom_range(127);
        ke = $urandom_range(127);
      end
      send_parents(fa, sa, kb, ke);
      sent += n;
      if ($urandom_range(9) == 0) begin
        release_input();
        wait_children();
      end
    end
    steady_mode = 1'b0;
  endtask

  // Receiver stall: random, a long hold on request, none in steady stretches.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (steady_mode || rst) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each accepted child transaction with the oldest expectation.
  always @(posedge clk) begin : check_child
    child_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_children.size() == 0) begin
        $error("unexpected child transaction: child_value %0d", child_value);
        error_count++;
      end else begin
        want = expected_children.pop_front();
        children_checked++;
        if (child_value !== want.value) begin
          $error("child_value: expected %0d, actual %0d", want.value, child_value);
          error_count++;
        end
        if (child_last !== want.is_last) begin
          $error("child_last: expected %0d, actual %0d", want.is_last, child_last);
          error_count++;
        end
        if (parents_invalid !== want.invalid) begin
          $error("parents_invalid: expected %0d, actual %0d", want.invalid, parents_invalid);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    first_parent_value = '0;
    second_parent_value = '0;
    keep_begin = '0;
    keep_end = '0;
    last_element = 1'b0;
    stored_pairs = 0;
    repeat_found = 1'b0;
    for (int k = 0; k < VAL_COUNT; k++) begin
      kept_mark[k] = 1'b0;
      first_mark[k] = 1'b0;
      second_mark[k] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_element();
    test_empty_range();
    test_clamped_range();
    test_range_past_length();
    test_invalid_parents();
    test_too_many_elements();
    test_output_hold();
    test_sender_pause();
    test_random_crossovers(5, 1'b0);
    test_random_crossovers(10, 1'b1);
    test_random_crossovers(5, 1'b0);

    release_input();
    wait_children();
    repeat (40) @(posedge clk);
    if (expected_children.size() != 0) begin
      $error("%0d child elements never arrived", expected_children.size());
      error_count++;
    end
    $display("Run covered %0d parent pairs in %0d crossovers; %0d child elements checked.",
             pairs_accepted, crossovers_started, children_checked);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
